// ===== rtl/core/irq_handler_table_dispatch_macros.svh =====
// ----------------------------------------------------------------------------
// Interrupt handler table assertion macros
// Concurrent assertion wrappers shared by the dispatch table RTL.
// ----------------------------------------------------------------------------
`ifndef IRQ_HANDLER_TABLE_DISPATCH_MACROS_SVH
`define IRQ_HANDLER_TABLE_DISPATCH_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define IHTD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle of its antecedent.
`define IHTD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define IHTD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ihtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt handler table package
// Item types, status codes and id constants for the dispatch table.
// ----------------------------------------------------------------------------
package ihtd_pkg;

   localparam int unsigned ID_W = 10;

   localparam logic [ID_W-1:0] ID_MASK        = 10'h3FF;
   localparam logic [ID_W-1:0] SPURIOUS_FIRST = 10'd1020;

   localparam logic [2:0] STATUS_REGISTERED = 3'd0;
   localparam logic [2:0] STATUS_FULL       = 3'd1;
   localparam logic [2:0] STATUS_FOUND      = 3'd2;
   localparam logic [2:0] STATUS_NONE       = 3'd3;
   localparam logic [2:0] STATUS_SPURIOUS   = 3'd4;

   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef struct packed {
      logic            op;
      logic [ID_W-1:0] intid;
      logic [31:0]     handler_ref;
      logic [63:0]     context_ref;
      logic [31:0]     ack_word;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [3:0]      slot_index;
      logic [31:0]     handler_out;
      logic [63:0]     context_out;
      logic            eoi_valid;
      logic [31:0]     eoi_word;
      logic [ID_W-1:0] masked_id;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [31:0]     handler;
      logic [63:0]     ctx;
   } slot_type;

endpackage

// ===== rtl/core/irq_handler_table_dispatch.sv =====
// ----------------------------------------------------------------------------
// Interrupt handler table with dispatch
// Registers handlers into the lowest free slot and looks up acknowledged ids.
// ----------------------------------------------------------------------------
// A registration, a spurious dispatch or a dispatch to an empty table goes from idle straight to emit.
// A lookup reads the slot memory one entry per cycle in scan, then goes to emit.
// One item is in work at a time, so a new item is taken only once the last has
// left emit; a new item is taken while a result waits.
// Reset empties the table through a fill count; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "irq_handler_table_dispatch_macros.svh"

module irq_handler_table_dispatch #(
   parameter int unsigned SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ihtd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ihtd_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [IDX_W-1:0]    ptr_ff;
   ihtd_pkg::rsp_type   res_ff;
   ihtd_pkg::rsp_type   res_in;
   ihtd_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   ihtd_pkg::slot_type  mem [SLOTS];
   ihtd_pkg::slot_type  rd_ff;

   logic                 accept;
   logic                 full;
   logic                 last;
   logic                 mem_we;
   logic                 rsp_load;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr_in;
   logic [ihtd_pkg::ID_W-1:0] mid;
   ihtd_pkg::slot_type   wr_entry;
   logic [IDX_W+3:0]     wr_wide;
   logic [IDX_W+3:0]     ptr_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == CNT_W'(SLOTS));
   assign last      = ((CNT_W'(ptr_ff) + CNT_W'(1)) == fill_ff);
   assign wr_addr   = fill_ff[IDX_W-1:0];
   assign mem_we    = accept && (req_data.op == ihtd_pkg::OP_REGISTER) && !full;
   assign mid       = req_data.ack_word[ihtd_pkg::ID_W-1:0] & ihtd_pkg::ID_MASK;
   assign wr_wide   = {4'b0000, wr_addr};
   assign ptr_wide  = {4'b0000, ptr_ff};
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign wr_entry.id      = req_data.intid;
   assign wr_entry.handler = req_data.handler_ref;
   assign wr_entry.ctx     = req_data.context_ref;

   always_comb begin
      if (state_ff == ST_SCAN && !last) begin
         rd_addr_in = ptr_ff + IDX_W'(1);
      end else begin
         rd_addr_in = '0;
      end
   end

   always_comb begin
      res_in = '0;
      if (req_data.op == ihtd_pkg::OP_REGISTER) begin
         if (full) begin
            res_in.status = ihtd_pkg::STATUS_FULL;
         end else begin
            res_in.status     = ihtd_pkg::STATUS_REGISTERED;
            res_in.slot_index = wr_wide[3:0];
         end
      end else begin
         res_in.masked_id = mid;
         if (mid >= ihtd_pkg::SPURIOUS_FIRST) begin
            res_in.status = ihtd_pkg::STATUS_SPURIOUS;
         end else begin
            res_in.status    = ihtd_pkg::STATUS_NONE;
            res_in.eoi_valid = 1'b1;
            res_in.eoi_word  = req_data.ack_word;
         end
      end
   end

   // Registration only happens in idle, when no lookup is under way, so a lookup
   // read never overlaps a write to the same slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_ff <= mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  res_ff <= res_in;
                  ptr_ff <= '0;
                  if (req_data.op == ihtd_pkg::OP_REGISTER) begin
                     if (!full) begin
                        fill_ff <= fill_ff + CNT_W'(1);
                     end
                     state_ff <= ST_EMIT;
                  end else if (mid >= ihtd_pkg::SPURIOUS_FIRST || fill_ff == '0) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (rd_ff.id == res_ff.masked_id) begin
                  res_ff.status      <= ihtd_pkg::STATUS_FOUND;
                  res_ff.slot_index  <= ptr_wide[3:0];
                  res_ff.handler_out <= rd_ff.handler;
                  res_ff.context_out <= rd_ff.ctx;
                  state_ff           <= ST_EMIT;
               end else if (last) begin
                  state_ff <= ST_EMIT;
               end else begin
                  ptr_ff <= ptr_ff + IDX_W'(1);
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IHTD_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(SLOTS), "Fill count beyond table size")
   `IHTD_ASSERT_IMPL(a_scan_in_range, clock, reset, state_ff == ST_SCAN, CNT_W'(ptr_ff) < fill_ff, "Lookup pointer past filled slots")
   `IHTD_ASSERT_IMPL(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT, "Result raised outside emit")
   `IHTD_ASSERT_NEXT(a_reg_grows, clock, reset, mem_we, fill_ff == $past(fill_ff) + CNT_W'(1), "Registration did not take a slot")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Interrupt handler table dispatch testbench
// Drives register and dispatch items through the valid/ready request channel
// and checks every result against a scoreboard that keeps its own copy of the
// handler table. A directed opening covers empty-table lookups, spurious ids,
// duplicate and zero-handler entries. It is followed by random traffic in
// phases with and without idling on either side, a long result hold-off, and
// drains between the phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOTS       = 16;
   localparam int PHASE_ITEMS = 275;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;

   class irq_table_scoreboard;
      bit                   used     [SLOTS];
      logic [9:0]           ids      [SLOTS];
      logic [31:0]          handlers [SLOTS];
      logic [63:0]          contexts [SLOTS];
      ihtd_pkg::rsp_type    outcomes [$];
      int                   mismatches;

      function void note_request(ihtd_pkg::req_type r);
         ihtd_pkg::rsp_type o;
         logic [9:0]        mid;
         o = '0;
         if (r.op == ihtd_pkg::OP_REGISTER) begin
            o.status = ihtd_pkg::STATUS_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!used[i]) begin
                  used[i]     = 1'b1;
                  ids[i]      = r.intid;
                  handlers[i] = r.handler_ref;
                  contexts[i] = r.context_ref;
                  o.status     = ihtd_pkg::STATUS_REGISTERED;
                  o.slot_index = i[3:0];
                  break;
               end
            end
         end else begin
            mid = r.ack_word[9:0] & ihtd_pkg::ID_MASK;
            o.masked_id = mid;
            if (mid >= ihtd_pkg::SPURIOUS_FIRST) begin
               o.status = ihtd_pkg::STATUS_SPURIOUS;
            end else begin
               o.eoi_valid = 1'b1;
               o.eoi_word  = r.ack_word;
               o.status    = ihtd_pkg::STATUS_NONE;
               for (int i = 0; i < SLOTS; i++) begin
                  if (used[i] && ids[i] == mid) begin
                     o.status      = ihtd_pkg::STATUS_FOUND;
                     o.slot_index  = i[3:0];
                     o.handler_out = handlers[i];
                     o.context_out = contexts[i];
                     break;
                  end
               end
            end
         end
         outcomes.push_back(o);
      endfunction

      function void check_response(ihtd_pkg::rsp_type got);
         ihtd_pkg::rsp_type want;
         if (outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result item: %p", got);
            return;
         end
         want = outcomes.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch (expected/actual): status %0d/%0d slot %0d/%0d ",
                         "handler %h/%h context %h/%h eoi %b/%b word %h/%h id %0d/%0d"},
                        want.status, got.status, want.slot_index, got.slot_index,
                        want.handler_out, got.handler_out, want.context_out, got.context_out,
                        want.eoi_valid, got.eoi_valid, want.eoi_word, got.eoi_word,
                        want.masked_id, got.masked_id);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ihtd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ihtd_pkg::rsp_type rsp_data;

   irq_table_scoreboard sb;
   int         send_idle_pct;
   int         stall_pct;
   bit         hold_request;
   int         quiet_cycles;
   int         registrations;
   logic [9:0] known_ids [$];

   irq_handler_table_dispatch #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The long hold-off is counted here so that the sender keeps offering items.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic ihtd_pkg::req_type random_fields();
      ihtd_pkg::req_type r;
      r.op          = 1'($urandom_range(1));
      r.intid       = 10'($urandom_range(1023));
      r.handler_ref = $urandom;
      r.context_ref = {$urandom, $urandom};
      r.ack_word    = $urandom;
      return r;
   endfunction

   task automatic offer(input ihtd_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic offer_register(input logic [9:0] id, input logic [31:0] handler,
                                 input logic [63:0] ctx);
      ihtd_pkg::req_type r;
      r             = random_fields();
      r.op          = ihtd_pkg::OP_REGISTER;
      r.intid       = id;
      r.handler_ref = handler;
      r.context_ref = ctx;
      if (registrations < SLOTS)
         known_ids.push_back(id);
      registrations++;
      offer(r);
   endtask

   task automatic offer_dispatch(input logic [31:0] ack);
      ihtd_pkg::req_type r;
      r          = random_fields();
      r.op       = ihtd_pkg::OP_DISPATCH;
      r.ack_word = ack;
      offer(r);
   endtask

   task automatic offer_random();
      ihtd_pkg::req_type r;
      int                reg_pct;
      int                pick;
      r       = random_fields();
      reg_pct = (registrations < SLOTS) ? 10 : 3;
      if ($urandom_range(99) < reg_pct) begin
         if (known_ids.size() > 0 && $urandom_range(3) == 0)
            r.intid = known_ids[$urandom_range(known_ids.size() - 1)];
         offer_register(r.intid, r.handler_ref, r.context_ref);
      end else begin
         pick = $urandom_range(99);
         if (pick < 60 && known_ids.size() > 0)
            r.ack_word[9:0] = known_ids[$urandom_range(known_ids.size() - 1)];
         else if (pick < 75)
            r.ack_word[9:0] = 10'($urandom_range(1023, 1020));
         offer_dispatch(r.ack_word);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outcomes.size() != 0) @(posedge clock);
   endtask

   initial begin
      sb            = new();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b0;
      registrations = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      offer_dispatch(32'h0000_0000);
      offer_dispatch(32'hFFFF_FFFF);
      offer_dispatch(32'h5A5A_5BFC);
      offer_dispatch(32'h8000_03FB);
      offer_register(10'd0, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_register(10'd1023, 32'hFFFF_FFFF, 64'h0000_0000_0000_0000);
      offer_register(10'd1020, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
      offer_register(10'd5, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
      offer_register(10'd5, 32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5);
      offer_register(10'd1019, 32'h0BAD_F00D, 64'hFEDC_BA98_7654_3210);
      offer_dispatch(32'hFFFF_FC00);
      offer_dispatch(32'h0000_03FF);
      offer_dispatch(32'h0000_03FC);
      offer_dispatch(32'hC000_0005);
      offer_dispatch(32'h7FFF_FBFB);
      offer_dispatch(32'h0000_0200);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 100)
               hold_request = 1'b1;
            offer_random();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outcomes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
